// ----- src/positional_list_store_assert.svh -----
// ---------------------------------------------------------------------------
// positional list store assertion macros
// shared concurrent assertion forms, clocked and reset-qualified
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_STORE_ASSERT_SVH
`define POSITIONAL_LIST_STORE_ASSERT_SVH

// condition that holds at every clock edge out of reset
`define PLS_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// consequence in the same cycle
`define PLS_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the following cycle
`define PLS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/pls_pkg.sv -----
// ---------------------------------------------------------------------------
// pls_pkg
// types and constants shared by the positional list store modules
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pls_pkg;

	localparam int PosBits     = 7;
	localparam int ValBits     = 32;
	localparam int CntBits     = 7;
	localparam int QUEUE_DEPTH = 2;

	typedef enum logic [2:0] {
		OP_INSERT   = 3'd0,
		OP_DELETE   = 3'd1,
		OP_RETRIEVE = 3'd2,
		OP_REPLACE  = 3'd3,
		OP_CLEAR    = 3'd4,
		OP_TRAVERSE = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_BADPOS = 2'd1,
		ST_FULL   = 2'd2,
		ST_EMPTY  = 2'd3
	} status_t;

	// what the back end does to the cells
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_INSERT,
		ACT_DELETE,
		ACT_READ,
		ACT_REPLACE,
		ACT_TRAVERSE
	} act_t;

	typedef enum logic {
		BK_IDLE,
		BK_TRAV
	} bk_state_t;

	// classified command, front to back
	typedef struct packed {
		act_t                 act;
		logic [PosBits-1:0]   pos;
		logic [ValBits-1:0]   value;
		status_t              status;
		logic [CntBits-1:0]   count;
	} cmd_t;

endpackage

// ----- src/pls_front.sv -----
// ---------------------------------------------------------------------------
// pls_front
// accepts items, checks bounds against the projected count, builds commands
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pls_front import pls_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [2:0]          operation,
	input  logic [PosBits-1:0]  position,
	input  logic [ValBits-1:0]  value_in,
	input  logic                full,
	output logic                push,
	output cmd_t                cmd
);

	localparam int CW = $clog2(DEPTH + 1);

	// count as it stands once every queued command has run
	logic [CW-1:0]      count_q;
	logic [CW-1:0]      count_next;
	logic [PosBits-1:0] cnt_ext;

	assign push    = start && !full;
	assign cnt_ext = PosBits'(count_q);

	always_comb begin
		cmd        = '0;
		cmd.act    = ACT_NONE;
		cmd.pos    = position;
		cmd.value  = value_in;
		cmd.status = ST_OK;
		count_next = count_q;
		case (op_t'(operation))
			OP_INSERT: begin
				if (count_q == CW'(DEPTH)) begin
					cmd.status = ST_FULL;
				end else if (position > cnt_ext) begin
					cmd.status = ST_BADPOS;
				end else begin
					cmd.act    = ACT_INSERT;
					count_next = count_q + CW'(1);
				end
			end
			OP_DELETE: begin
				if (count_q == '0) begin
					cmd.status = ST_EMPTY;
				end else if (position >= cnt_ext) begin
					cmd.status = ST_BADPOS;
				end else begin
					cmd.act    = ACT_DELETE;
					count_next = count_q - CW'(1);
				end
			end
			OP_RETRIEVE: begin
				if (position >= cnt_ext) cmd.status = ST_BADPOS;
				else cmd.act = ACT_READ;
			end
			OP_REPLACE: begin
				if (position >= cnt_ext) cmd.status = ST_BADPOS;
				else cmd.act = ACT_REPLACE;
			end
			OP_CLEAR: begin
				count_next = '0;
			end
			OP_TRAVERSE: begin
				if (count_q == '0) cmd.status = ST_EMPTY;
				else cmd.act = ACT_TRAVERSE;
			end
			default: begin
			end
		endcase
		cmd.count = CntBits'(count_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (push) begin
			count_q <= count_next;
		end
	end

endmodule

// ----- src/pls_queue.sv -----
// ---------------------------------------------------------------------------
// pls_queue
// short command queue between front and back
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_list_store_assert.svh"

module pls_queue import pls_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t cmd,
	input  logic pop,
	output cmd_t head,
	output logic full,
	output logic empty
);

	localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int LW = $clog2(QUEUE_DEPTH + 1);

	cmd_t          mem_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [LW-1:0] level_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (level_q == LW'(QUEUE_DEPTH));
	assign empty   = (level_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign head    = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			case ({do_push, do_pop})
				2'b10:   level_q <= level_q + LW'(1);
				2'b01:   level_q <= level_q - LW'(1);
				default: level_q <= level_q;
			endcase
		end
	end

	`PLS_ASSERT_NEXT(a_queue_grows, clk, arst_n, do_push && !do_pop, level_q == $past(level_q) + LW'(1), "queue level did not grow on push")
	`PLS_ASSERT_ALWAYS(a_queue_bound, clk, arst_n, level_q <= LW'(QUEUE_DEPTH), "queue level beyond depth")

endmodule

// ----- src/pls_back.sv -----
// ---------------------------------------------------------------------------
// pls_back
// shifting cell row, read mux, traverse sequencer and result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "positional_list_store_assert.svh"

module pls_back import pls_pkg::*; #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                head,
	input  logic                empty,
	output logic                pop,
	output logic                strobe,
	output logic [ValBits-1:0]  value_out,
	output logic [CntBits-1:0]  entry_count,
	output status_t             status,
	output logic                last
);

	localparam int CW = $clog2(DEPTH + 1);
	localparam int IW = $clog2(DEPTH);
	localparam int SW = (WORD_BITS < ValBits) ? WORD_BITS : ValBits;

	logic [SW-1:0]      cells_q [DEPTH];
	bk_state_t          state_q;
	bk_state_t          state_next;
	logic [IW-1:0]      idx_q;
	logic [IW-1:0]      idx_next;
	logic [CW-1:0]      trav_cnt_q;
	logic [CW-1:0]      trav_cnt_next;
	logic [CW-1:0]      idx_plus;

	act_t               cell_op;
	logic [PosBits-1:0] op_pos;
	logic [SW-1:0]      op_word;
	logic [IW-1:0]      rd_idx;
	logic [SW-1:0]      rd_word;

	logic               res_valid;
	logic [ValBits-1:0] res_value;
	logic [CntBits-1:0] res_count;
	status_t            res_status;
	logic               res_last;

	logic               strobe_q;
	logic [ValBits-1:0] value_q;
	logic [CntBits-1:0] count_q;
	status_t            status_q;
	logic               last_q;

	assign op_pos   = head.pos;
	assign op_word  = head.value[SW-1:0];
	assign rd_word  = cells_q[rd_idx];
	assign idx_plus = CW'(idx_q) + CW'(1);

	// next state
	always_comb begin
		state_next = state_q;
		case (state_q)
			BK_IDLE: begin
				if (!empty && head.act == ACT_TRAVERSE && head.count != CntBits'(1)) begin
					state_next = BK_TRAV;
				end
			end
			BK_TRAV: begin
				if (idx_plus == trav_cnt_q) state_next = BK_IDLE;
			end
			default: state_next = BK_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		pop           = 1'b0;
		cell_op       = ACT_NONE;
		rd_idx        = op_pos[IW-1:0];
		idx_next      = idx_q;
		trav_cnt_next = trav_cnt_q;
		res_valid     = 1'b0;
		res_value     = '0;
		res_count     = head.count;
		res_status    = head.status;
		res_last      = 1'b1;
		case (state_q)
			BK_IDLE: begin
				if (!empty) begin
					pop       = 1'b1;
					cell_op   = head.act;
					res_valid = 1'b1;
					case (head.act)
						ACT_DELETE, ACT_READ: begin
							res_value = ValBits'(rd_word);
						end
						ACT_TRAVERSE: begin
							// first beat comes straight off the pop
							rd_idx        = '0;
							res_value     = ValBits'(rd_word);
							res_last      = (head.count == CntBits'(1));
							idx_next      = IW'(1);
							trav_cnt_next = head.count[CW-1:0];
						end
						default: begin
						end
					endcase
				end
			end
			BK_TRAV: begin
				rd_idx     = idx_q;
				res_valid  = 1'b1;
				res_value  = ValBits'(rd_word);
				res_count  = CntBits'(trav_cnt_q);
				res_status = ST_OK;
				res_last   = (idx_plus == trav_cnt_q);
				idx_next   = idx_q + IW'(1);
			end
			default: begin
			end
		endcase
	end

	// cell row: every cell at or past the position shifts in the same cycle
	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		logic [SW-1:0] up_w;
		logic [SW-1:0] down_w;

		if (g == 0) begin : g_first
			assign up_w = cells_q[g];
		end else begin : g_up
			assign up_w = cells_q[g-1];
		end
		if (g == DEPTH - 1) begin : g_top
			assign down_w = cells_q[g];
		end else begin : g_down
			assign down_w = cells_q[g+1];
		end

		always_ff @(posedge clk) begin
			case (cell_op)
				ACT_INSERT: begin
					if (PosBits'(g) > op_pos) cells_q[g] <= up_w;
					else if (PosBits'(g) == op_pos) cells_q[g] <= op_word;
				end
				ACT_DELETE: begin
					if (PosBits'(g) >= op_pos) cells_q[g] <= down_w;
				end
				ACT_REPLACE: begin
					if (PosBits'(g) == op_pos) cells_q[g] <= op_word;
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= BK_IDLE;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_next;
			strobe_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		idx_q      <= idx_next;
		trav_cnt_q <= trav_cnt_next;
		value_q    <= res_value;
		count_q    <= res_count;
		status_q   <= res_status;
		last_q     <= res_last;
	end

	assign strobe      = strobe_q;
	assign value_out   = value_q;
	assign entry_count = count_q;
	assign status      = status_q;
	assign last        = last_q;

	`PLS_ASSERT_NEXT(a_trav_beat, clk, arst_n, state_q == BK_TRAV, strobe_q, "traverse cycle gave no beat")
	`PLS_ASSERT_IMPLIES(a_err_no_data, clk, arst_n, strobe_q && status_q != ST_OK, value_q == '0, "error beat carries data")
	`PLS_ASSERT_IMPLIES(a_open_beat, clk, arst_n, strobe_q && !last_q, state_q == BK_TRAV, "non-final beat outside traverse")

endmodule

// ----- src/positional_list_store.sv -----
// ---------------------------------------------------------------------------
// positional_list_store
// ordered list of up to DEPTH words with insert, delete, retrieve, replace,
// clear and traverse by position
// ---------------------------------------------------------------------------
// an item is taken on a clock edge with start high and busy low. results come
// out one beat per cycle, marked by strobe, and cannot be held off by the
// receiver, so the block never stalls its output. each item passes the
// command queue and the back end's result register before its first result
// is driven; a traverse ahead of it can hold it in the queue. insert, delete,
// retrieve, replace, clear, unknown codes and every rejected item give one
// beat with last set and run at one item per cycle while no traverse holds
// the back end: every cell at or past the position shifts together. traverse
// gives one beat per stored entry (one beat with status empty on an empty
// list), so it holds the back end until its last beat, as the cell row has a
// single read port. bounds are checked at the front against the count the
// list will have once queued work is done, so a two-entry command queue lets
// items keep arriving during a traverse; busy rises only when that queue is
// full. value_out is zero on every beat that reads no entry.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_store import pls_pkg::*; #(
	parameter int DEPTH     = 64,
	parameter int WORD_BITS = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	// command side
	input  logic                start,
	output logic                busy,
	input  logic [2:0]          operation,
	input  logic [PosBits-1:0]  position,
	input  logic [ValBits-1:0]  value_in,
	// result side, one beat per strobe
	output logic                strobe,
	output logic [ValBits-1:0]  value_out,
	output logic [CntBits-1:0]  entry_count,
	output logic                is_empty,
	output logic                is_full,
	output logic [1:0]          status,
	output logic                last
);

	// front to queue
	logic    push;
	cmd_t    cmd;
	// queue to back
	cmd_t    head;
	logic    pop;
	logic    q_full;
	logic    q_empty;
	status_t res_status;

	// front: classify against the projected count
	pls_front #(
		.DEPTH (DEPTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.operation (operation),
		.position  (position),
		.value_in  (value_in),
		.full      (q_full),
		.push      (push),
		.cmd       (cmd)
	);

	// decoupling queue
	pls_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.cmd    (cmd),
		.pop    (pop),
		.head   (head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// back: cell row and result register
	pls_back #(
		.DEPTH     (DEPTH),
		.WORD_BITS (WORD_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.empty       (q_empty),
		.pop         (pop),
		.strobe      (strobe),
		.value_out   (value_out),
		.entry_count (entry_count),
		.status      (res_status),
		.last        (last)
	);

	// busy only while the queue cannot take another command
	assign busy = q_full;

	// flags follow the count carried with each beat
	assign status   = res_status;
	assign is_empty = (entry_count == '0);
	assign is_full  = (entry_count == CntBits'(DEPTH));

endmodule

// ----- verif/positional_list_store_tb.sv -----
// ---------------------------------------------------------------------------
// positional_list_store_tb
// self-checking bench for the positional list store: a shadow copy of the
// list predicts every result beat, which is compared field by field with
// what the block puts out; directed corner cases first, then random traffic
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module positional_list_store_tb import pls_pkg::*; ;

	localparam int ListDepth   = 64;
	localparam int RandomItems = 320;
	localparam int StallLimit  = 1000;  // cycles with no beat moving on either side
	localparam int DrainCycles = 8;     // idle cycles after the last owed beat has arrived

	// codes the block must treat as no-ops
	localparam logic [2:0] OP_SPARE_LO = 3'd6;
	localparam logic [2:0] OP_SPARE_HI = 3'd7;

	typedef enum {
		MIX_GROW,
		MIX_SHRINK,
		MIX_EVEN,
		MIX_FILL
	} mix_t;

	// shadow of the list contents and count, plus the beats still owed
	class list_shadow;

		typedef struct {
			logic [ValBits-1:0] value;
			logic [CntBits-1:0] count;
			logic               empty;
			logic               full;
			status_t            status;
			logic               last;
		} beat_t;

		logic [ValBits-1:0] cells [ListDepth];
		int                 used;
		beat_t              owed_beats [$];
		int unsigned        faults;

		function void queue_beat(logic [ValBits-1:0] value, status_t status, logic last);
			beat_t b;
			b.value  = value;
			b.count  = used[CntBits-1:0];
			b.empty  = (used == 0);
			b.full   = (used == ListDepth);
			b.status = status;
			b.last   = last;
			owed_beats.push_back(b);
		endfunction

		// update the shadow for one accepted command and queue its beats
		function void take_command(logic [2:0] op, logic [PosBits-1:0] pos,
				logic [ValBits-1:0] val);
			int           i;
			int           p;
			logic [ValBits-1:0] got;
			p = int'(pos);
			case (op)
			OP_INSERT: begin
				if (used >= ListDepth) begin
					queue_beat('0, ST_FULL, 1'b1);
				end else if (p > used) begin
					queue_beat('0, ST_BADPOS, 1'b1);
				end else begin
					for (i = used; i > p; i--)
						cells[i] = cells[i-1];
					cells[p] = val;
					used++;
					queue_beat('0, ST_OK, 1'b1);
				end
			end
			OP_DELETE: begin
				if (used == 0) begin
					queue_beat('0, ST_EMPTY, 1'b1);
				end else if (p >= used) begin
					queue_beat('0, ST_BADPOS, 1'b1);
				end else begin
					got = cells[p];
					for (i = p; i + 1 < used; i++)
						cells[i] = cells[i+1];
					used--;
					queue_beat(got, ST_OK, 1'b1);
				end
			end
			OP_RETRIEVE: begin
				if (p >= used)
					queue_beat('0, ST_BADPOS, 1'b1);
				else
					queue_beat(cells[p], ST_OK, 1'b1);
			end
			OP_REPLACE: begin
				if (p >= used) begin
					queue_beat('0, ST_BADPOS, 1'b1);
				end else begin
					cells[p] = val;
					queue_beat('0, ST_OK, 1'b1);
				end
			end
			OP_CLEAR: begin
				used = 0;
				queue_beat('0, ST_OK, 1'b1);
			end
			OP_TRAVERSE: begin
				if (used == 0) begin
					queue_beat('0, ST_EMPTY, 1'b1);
				end else begin
					for (i = 0; i < used; i++)
						queue_beat(cells[i], ST_OK, i == used - 1);
				end
			end
			default: begin
				queue_beat('0, ST_OK, 1'b1);
			end
			endcase
		endfunction

		function void compare_field(string name, logic [ValBits-1:0] want,
				logic [ValBits-1:0] got);
			if (want !== got) begin
				$error("%s: expected %0h, got %0h", name, want, got);
				faults++;
			end
		endfunction

		function void check_beat(logic [ValBits-1:0] value, logic [CntBits-1:0] count,
				logic empty, logic full, logic [1:0] status, logic last);
			beat_t b;
			if (owed_beats.size() == 0) begin
				$error("result beat with nothing owed: value_out %0h status %0d", value, status);
				faults++;
			end else begin
				b = owed_beats.pop_front();
				compare_field("value_out", b.value, value);
				compare_field("entry_count", ValBits'(b.count), ValBits'(count));
				compare_field("is_empty", ValBits'(b.empty), ValBits'(empty));
				compare_field("is_full", ValBits'(b.full), ValBits'(full));
				compare_field("status", ValBits'(b.status), ValBits'(status));
				compare_field("last", ValBits'(b.last), ValBits'(last));
			end
		endfunction

		function int owed();
			return owed_beats.size();
		endfunction

	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic [2:0]         operation = '0;
	logic [PosBits-1:0] position = '0;
	logic [ValBits-1:0] value_in = '0;
	logic               busy;
	logic               strobe;
	logic [ValBits-1:0] value_out;
	logic [CntBits-1:0] entry_count;
	logic               is_empty;
	logic               is_full;
	logic [1:0]         status;
	logic               last;

	list_shadow shadow = new();

	bit   burst;        // when set, commands go back to back
	int   stall_cycles;

	positional_list_store #(
		.DEPTH    (ListDepth),
		.WORD_BITS(ValBits)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.operation  (operation),
		.position   (position),
		.value_in   (value_in),
		.strobe     (strobe),
		.value_out  (value_out),
		.entry_count(entry_count),
		.is_empty   (is_empty),
		.is_full    (is_full),
		.status     (status),
		.last       (last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side: every strobed beat is checked against the oldest owed beat
	always @(posedge clk) begin
		if (arst_n && strobe)
			shadow.check_beat(value_out, entry_count, is_empty, is_full, status, last);
	end

	// watchdog: count cycles in which neither a command nor a result beat moves
	always @(posedge clk) begin
		if (!arst_n || strobe || (start && !busy))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		wait (stall_cycles >= StallLimit);
		$display("end of test: mismatches");
		$finish;
	end

	// one command beat: optional gap, then hold start until busy is low at an edge.
	// entered right after an edge; the shadow is updated on the accepting edge so
	// the caller always shapes the next command from the current list size
	task automatic issue(input logic [2:0] op, input logic [PosBits-1:0] pos,
			input logic [ValBits-1:0] val);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start     <= 1'b1;
		operation <= op;
		position  <= pos;
		value_in  <= val;
		@(posedge clk);
		while (busy) @(posedge clk);
		shadow.take_command(op, pos, val);
	endtask

	// operation mix per traffic flavor
	function automatic logic [2:0] pick_op(mix_t mix);
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return r[0] ? OP_SPARE_HI : OP_SPARE_LO;
		if (r < 5)
			return OP_CLEAR;
		if (r < 11)
			return OP_TRAVERSE;
		case (mix)
		MIX_GROW:   return (r < 70) ? OP_INSERT : (r < 80) ? OP_DELETE
				: (r < 90) ? OP_RETRIEVE : OP_REPLACE;
		MIX_SHRINK: return (r < 30) ? OP_INSERT : (r < 75) ? OP_DELETE
				: (r < 88) ? OP_RETRIEVE : OP_REPLACE;
		default:    return (r < 45) ? OP_INSERT : (r < 65) ? OP_DELETE
				: (r < 83) ? OP_RETRIEVE : OP_REPLACE;
		endcase
	endfunction

	// mostly in-range positions, now and then anything the field can carry
	function automatic logic [PosBits-1:0] pick_pos(logic [2:0] op);
		int n;
		n = shadow.used;
		if ($urandom_range(0, 9) == 0)
			return PosBits'($urandom_range(0, (1 << PosBits) - 1));
		if (op == OP_INSERT)
			return PosBits'($urandom_range(0, n));
		return (n == 0) ? PosBits'($urandom_range(0, 3)) : PosBits'($urandom_range(0, n - 1));
	endfunction

	initial begin
		int   sent;
		int   seg;
		int   len;
		mix_t mix;
		logic [2:0] op;

		burst = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-list rejects first
		issue(OP_TRAVERSE, PosBits'(0), '0);    // traverse on empty list
		issue(OP_DELETE,   PosBits'(0), '0);    // delete on empty list
		issue(OP_RETRIEVE, PosBits'(0), '0);    // any position is bad when empty
		issue(OP_REPLACE,  PosBits'(0), '1);
		issue(OP_INSERT,   PosBits'(1), '1);    // insert past the end
		// build three entries: head, append, middle
		issue(OP_INSERT,   PosBits'(0), '1);
		issue(OP_INSERT,   PosBits'(1), '0);
		issue(OP_INSERT,   PosBits'(1), 32'h5a5a_a5a5);
		issue(OP_INSERT,   '1, 32'h1234_5678);  // top position, far past the end
		issue(OP_RETRIEVE, PosBits'(0), '0);
		issue(OP_RETRIEVE, PosBits'(2), '0);
		issue(OP_RETRIEVE, PosBits'(3), '0);    // position equal to count
		issue(OP_REPLACE,  PosBits'(2), 32'h8000_0001);
		issue(OP_REPLACE,  '1, '1);
		issue(OP_TRAVERSE, PosBits'(0), '0);
		issue(OP_DELETE,   PosBits'(3), '0);    // delete at count is rejected
		issue(OP_DELETE,   PosBits'(1), '0);
		issue(OP_DELETE,   PosBits'(1), '0);    // now the tail
		issue(OP_SPARE_LO, PosBits'(0), '0);
		issue(OP_SPARE_HI, '1, '1);
		issue(OP_CLEAR,    '1, '1);
		issue(OP_TRAVERSE, PosBits'(0), '0);
		issue(OP_INSERT,   PosBits'(0), $urandom);

		// random: segments of one flavor each, one segment fills the list
		sent = 0;
		seg  = 0;
		while (sent < RandomItems) begin
			mix   = (seg == 2) ? MIX_FILL : mix_t'($urandom_range(0, 2));
			burst = ($urandom_range(0, 3) == 0);
			if (mix == MIX_FILL) begin
				while (shadow.used < ListDepth) begin
					issue(OP_INSERT, PosBits'($urandom_range(0, shadow.used)), $urandom);
					sent++;
				end
				// full list corners
				issue(OP_INSERT,   PosBits'(0), $urandom);
				issue(OP_INSERT,   PosBits'(ListDepth), $urandom);
				issue(OP_TRAVERSE, PosBits'(0), '0);
				issue(OP_RETRIEVE, PosBits'(ListDepth - 1), '0);
				issue(OP_DELETE,   PosBits'(ListDepth - 1), '0);
				issue(OP_INSERT,   PosBits'(ListDepth - 1), $urandom);
				sent += 6;
			end else begin
				len = $urandom_range(10, 40);
				repeat (len) begin
					op = pick_op(mix);
					issue(op, pick_pos(op), $urandom);
					sent++;
				end
			end
			seg++;
		end
		start <= 1'b0;

		// let every owed beat arrive; a hang is caught by the watchdog
		while (shadow.owed() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (shadow.faults == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
